// ----- rtl/mqf_pkg.sv -----
// ============================================================================
// mqf_pkg: shared definitions for the multi-queue FIFO unit
// Field widths, status and operation codes, and the command record that
// travels from the front end to the back end.
// ============================================================================
`default_nettype none

package mqf_pkg;

  localparam int DATA_W          = 32;
  localparam int QID_W           = 3;
  localparam int STAT_W          = 2;
  localparam int CFG_W           = 4;
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // Operation codes.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  // One classified command.
  typedef struct packed {
    logic                     func;
    logic [QID_W-1:0]         qid;
    logic signed [DATA_W-1:0] data;
    logic                     range_err;
  } mqf_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/mqf_if.sv -----
// ============================================================================
// mqf_if: channel interfaces of the multi-queue FIFO unit
// Command channel into the block and result channel out of it, each with
// valid, ready and payload.
// ============================================================================
`default_nettype none

interface mqf_in_if import mqf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [QID_W-1:0]         queue_id;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output func, output queue_id, output data_in,
                  input ready);
  modport sink (input valid, input func, input queue_id, input data_in,
                output ready);
endinterface

interface mqf_out_if import mqf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/mqf_front.sv -----
// ============================================================================
// mqf_front: command intake and classification
// Holds the queue count register, accepts command transactions and tags
// each one with its range check before it enters the command queue.
// ============================================================================
`default_nettype none

module mqf_front import mqf_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  mqf_in_if.sink                in_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             q_full,
  output logic                  push_valid,
  output mqf_cmd_t              push_cmd
);

  localparam int NQ_W  = $clog2(NUM_QUEUES + 1);
  localparam int LIM_W = (NQ_W > CFG_W) ? NQ_W : CFG_W;
  localparam logic [LIM_W-1:0] NqLim = LIM_W'(NUM_QUEUES);

  logic [CFG_W-1:0] queue_count_r;
  logic [LIM_W-1:0] count_ext;
  logic [LIM_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_count_r <= CFG_RESET;
    end else if (cfg_we) begin
      queue_count_r <= cfg_data;
    end
  end

  // The usable queue count is capped at the number of queues built.
  always_comb begin
    count_ext = LIM_W'(queue_count_r);
    limit     = (count_ext > NqLim) ? NqLim : count_ext;
  end

  assign in_ch.ready = !q_full;
  assign push_valid  = in_ch.valid && !q_full;

  always_comb begin
    push_cmd.func      = in_ch.func;
    push_cmd.qid       = in_ch.queue_id;
    push_cmd.data      = in_ch.data_in;
    push_cmd.range_err = (LIM_W'(in_ch.queue_id) >= limit);
  end

endmodule

`default_nettype wire

// ----- rtl/mqf_cmd_fifo.sv -----
// ============================================================================
// mqf_cmd_fifo: command queue between front end and back end
// A short register queue that lets either side stall without the other.
// ============================================================================
`default_nettype none

module mqf_cmd_fifo import mqf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  input  wire mqf_cmd_t push_cmd,
  output logic          q_full,
  input  wire logic     pop,
  output logic          cmd_valid,
  output mqf_cmd_t      cmd
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  mqf_cmd_t         slot_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign q_full    = (count_r == CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_valid ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push_valid) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mqf_back.sv -----
// ============================================================================
// mqf_back: queue execution and result register
// Keeps head, tail and fill state of every queue, drives the shared word
// store and holds each result until the result channel takes it.
// ============================================================================
`default_nettype none

module mqf_back import mqf_pkg::*; #(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  input  wire mqf_cmd_t cmd,
  output logic          cmd_pop,
  mqf_out_if.source     out_ch
);

  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WORDS  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [SLOT_W-1:0]        head_r [NUM_QUEUES];
  logic [SLOT_W-1:0]        tail_r [NUM_QUEUES];
  logic [FILL_W-1:0]        fill_r [NUM_QUEUES];
  logic signed [DATA_W-1:0] mem [WORDS];

  logic signed [DATA_W-1:0] rdata_r;
  logic                     res_v_r, res_v_nxt;
  logic [STAT_W-1:0]        status_r;
  logic                     rd_ok_r;

  logic [QIDX_W-1:0] q;
  logic              is_full, is_empty;
  logic              do_wr, do_rd;
  logic [STAT_W-1:0] status_nxt;
  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] addr;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // A new command goes ahead only when the result register is free or
  // is being emptied in this cycle.
  assign cmd_pop = cmd_valid && (!res_v_r || out_ch.ready);

  always_comb begin
    q        = QIDX_W'(cmd.qid);
    is_full  = (fill_r[q] == FILL_W'(QUEUE_DEPTH));
    is_empty = (fill_r[q] == '0);
    do_wr    = cmd_pop && !cmd.range_err && (cmd.func == FUNC_ENQ) && !is_full;
    do_rd    = cmd_pop && !cmd.range_err && (cmd.func == FUNC_DEQ) && !is_empty;
    if (cmd.range_err) begin
      status_nxt = STAT_RANGE;
    end else if (cmd.func == FUNC_ENQ) begin
      status_nxt = is_full ? STAT_FULL : STAT_OK;
    end else begin
      status_nxt = is_empty ? STAT_EMPTY : STAT_OK;
    end
    slot      = (cmd.func == FUNC_ENQ) ? tail_r[q] : head_r[q];
    addr      = ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(slot);
    res_v_nxt = cmd_pop ? 1'b1 : (out_ch.ready ? 1'b0 : res_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= res_v_nxt;
      if (do_wr) begin
        tail_r[q] <= ring_next(tail_r[q]);
        fill_r[q] <= fill_r[q] + FILL_W'(1);
      end
      if (do_rd) begin
        head_r[q] <= ring_next(head_r[q]);
        fill_r[q] <= fill_r[q] - FILL_W'(1);
      end
    end
  end

  // Word store and registered read port.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[addr] <= cmd.data;
    end
    if (do_rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      status_r <= status_nxt;
      rd_ok_r  <= do_rd;
    end
  end

  assign out_ch.valid    = res_v_r;
  assign out_ch.status   = status_r;
  assign out_ch.data_out = rd_ok_r ? rdata_r : '0;

endmodule

`default_nettype wire

// ----- rtl/multi_queue_fifo_unit.sv -----
// ============================================================================
// multi_queue_fifo_unit: bank of independent FIFO queues of 32-bit words
// Top level: command intake, command queue and queue execution.
// ============================================================================
// Each command transaction on in_ch either appends data_in to queue
// queue_id (func 0) or removes that queue's oldest word (func 1), and each
// gives exactly one result transaction on out_ch with a status and, for a
// successful dequeue, the word removed. Every queue is a ring of QUEUE_DEPTH
// words in one shared word store. The block sustains one command per cycle
// while the result channel takes each result; that figure is set by the back
// end, which updates one queue's head, tail and fill count and makes one
// access to the single-port word store per cycle. A taken command first
// waits in the command queue and is then executed straight into the result
// register that holds the read data, from which the result channel takes it.
// The word store needs no clearing after reset, so commands are taken as
// soon as reset is released. The user must write queue_count through cfg_we
// and cfg_data only while the block is idle; the block does not enforce this.
`default_nettype none

module multi_queue_fifo_unit import mqf_pkg::*; #(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  mqf_in_if.sink                in_ch,
  mqf_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // Link between the front end and the command queue.
  logic     push_valid;
  mqf_cmd_t push_cmd;
  logic     q_full;

  // Link between the command queue and the back end.
  logic     cmd_valid;
  mqf_cmd_t cmd;
  logic     cmd_pop;

  // The front end owns the queue count and tags out-of-range commands, so
  // the back end never has to look at configuration.
  mqf_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // Two entries are enough to keep one command per cycle flowing while the
  // back end's ready depends on the result channel.
  mqf_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_full     (q_full),
    .pop        (cmd_pop),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd)
  );

  // The back end executes one command per cycle while the result channel keeps
  // taking results, and holds each result until the result channel takes it.
  mqf_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

  // A result with a failing status must carry a zero word.
  a_data_zero_on_fail : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != STAT_OK)) |-> (out_ch.data_out == '0))
    else $error("result with failing status carries nonzero data");

  // The back end must never take a command from an empty command queue.
  a_pop_needs_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty command queue");

  // A held result must not be overwritten by a new command.
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !cmd_pop)
    else $error("command executed while a result is still waiting");

endmodule

`default_nettype wire
